[rtl/mstk_pkg.sv]
// Shared field widths and the smallest node count for the Kruskal spanning-tree block.
package mstk_pkg;

   localparam int NODE_W   = 4;   // node index field width
   localparam int WT_W     = 16;  // weight field width on the ports
   localparam int CFG_W    = 5;   // node_count register width
   localparam int MIN_NODE = 2;   // smallest usable node count

endpackage

[rtl/minimum_spanning_tree_kruskal.sv]
// Kruskal minimum spanning tree over a streamed adjacency matrix.
//
//  channel | dir | handshake           | payload
//  req     | in  | req_valid/req_ready | row_node, col_node, edge_weight, last_entry
//  rsp     | out | rsp_valid/rsp_ready | tree_from, tree_to, tree_weight, tree_last, tree_empty
//  csr     | in  | csr_write           | csr_wdata (node_count)
//
// Loading accepts one matrix entry per cycle. After the last entry the root table is
// initialized for all MAX_NODES nodes, then each edge pick is one scan of the edge memory,
// two root reads, and for an accepted edge other than the last a relabel sweep of the root table.
// Reset is synchronous, clears control state and sets node_count to 5; the root table is initialized per graph.
// A stalled rsp holds the sequencer at the next emit or at finish; req_ready is low until the graph ends.
module minimum_spanning_tree_kruskal
   import mstk_pkg::*;
#(
   parameter int MAX_NODES   = 16,
   parameter int MAX_EDGES   = 128,
   parameter int WEIGHT_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [NODE_W-1:0] req_row_node,
   input  logic [NODE_W-1:0] req_col_node,
   input  logic [WT_W-1:0]   req_edge_weight,
   input  logic              req_last_entry,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [NODE_W-1:0] rsp_tree_from,
   output logic [NODE_W-1:0] rsp_tree_to,
   output logic [WT_W-1:0]   rsp_tree_weight,
   output logic              rsp_tree_last,
   output logic              rsp_tree_empty,
   input  logic              csr_write,
   input  logic [CFG_W-1:0]  csr_wdata
);

   localparam int NODE_BITS = $clog2(MAX_NODES);
   localparam int NCNT_W    = $clog2(MAX_NODES + 1);
   localparam int NUSE_W    = (NCNT_W > CFG_W) ? NCNT_W : CFG_W;
   localparam int EIDX_W    = $clog2(MAX_EDGES);
   localparam int ECNT_W    = $clog2(MAX_EDGES + 1);
   localparam int EDGE_W    = 2 * NODE_W + WEIGHT_BITS;
   localparam int KEY_W     = WEIGHT_BITS + EIDX_W;

   typedef enum logic [3:0] {
      ST_LOAD, ST_RINIT, ST_SCAN, ST_FIND_A, ST_FIND_B, ST_CHECK,
      ST_EMIT, ST_RELABEL, ST_FINISH
   } state_type;

   state_type              state_ff;
   logic [CFG_W-1:0]       node_count_ff;
   logic [ECNT_W-1:0]      edge_total_ff;
   logic [ECNT_W-1:0]      sc_ff;
   logic                   rd_v_ff;
   logic [EIDX_W-1:0]      rd_idx_ff;
   logic [NCNT_W-1:0]      cnt_ff;
   logic                   rl_v_ff;
   logic [NODE_BITS-1:0]   rl_idx_ff;
   logic [NCNT_W-1:0]      acc_ff;
   logic                   best_v_ff, prev_v_ff, pend_v_ff;
   logic [KEY_W-1:0]       best_key_ff, prev_key_ff;
   logic [NODE_W-1:0]      best_from_ff, best_to_ff, pend_from_ff, pend_to_ff;
   logic [WEIGHT_BITS-1:0] best_w_ff, pend_w_ff;
   logic [NODE_BITS-1:0]   ra_ff, rb_ff;

   // Memories
   logic [EDGE_W-1:0]      edge_mem [MAX_EDGES];
   logic [EDGE_W-1:0]      edge_q_ff;
   logic [NODE_BITS-1:0]   root_mem [MAX_NODES];
   logic [NODE_BITS-1:0]   root_q_ff;

   logic                   rsp_valid_ff, rsp_last_ff, rsp_empty_ff;
   logic [NODE_W-1:0]      rsp_from_ff, rsp_to_ff;
   logic [WT_W-1:0]        rsp_w_ff;

   logic [NUSE_W-1:0]      n_use;
   logic [WEIGHT_BITS-1:0] w_in;
   logic                   keep, accept_in, out_free;
   logic [NODE_BITS-1:0]   root_raddr, root_waddr, root_wdata;
   logic                   root_we;
   logic [WEIGHT_BITS-1:0] q_w;
   logic [KEY_W-1:0]       q_key;
   logic                   cand;

   // Clamped node count
   always_comb begin
      if (node_count_ff < CFG_W'(MIN_NODE)) begin
         n_use = NUSE_W'(MIN_NODE);
      end else if (NUSE_W'(node_count_ff) > NUSE_W'(MAX_NODES)) begin
         n_use = NUSE_W'(MAX_NODES);
      end else begin
         n_use = NUSE_W'(node_count_ff);
      end
   end

   assign req_ready = (state_ff == ST_LOAD);
   assign accept_in = req_valid && req_ready;
   assign w_in      = WEIGHT_BITS'(req_edge_weight);
   assign keep      = (req_col_node > req_row_node) && (w_in != '0)
                      && (NUSE_W'(req_col_node) < n_use)
                      && (edge_total_ff < ECNT_W'(MAX_EDGES));
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // Scan compare: key is weight then load index, so ties keep load order
   assign q_w   = edge_q_ff[WEIGHT_BITS-1:0];
   assign q_key = {q_w, rd_idx_ff};
   assign cand  = rd_v_ff && (!prev_v_ff || (q_key > prev_key_ff))
                  && (!best_v_ff || (q_key < best_key_ff));

   // Root table port selection
   always_comb begin
      root_raddr = NODE_BITS'(best_from_ff);
      root_we    = 1'b0;
      root_waddr = rl_idx_ff;
      root_wdata = ra_ff;
      unique case (state_ff)
         ST_FIND_B:  root_raddr = NODE_BITS'(best_to_ff);
         ST_RELABEL: begin
            root_raddr = cnt_ff[NODE_BITS-1:0];
            root_we    = rl_v_ff && (root_q_ff == rb_ff);
         end
         ST_RINIT: begin
            root_we    = 1'b1;
            root_waddr = cnt_ff[NODE_BITS-1:0];
            root_wdata = cnt_ff[NODE_BITS-1:0];
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (root_we) begin
         root_mem[root_waddr] <= root_wdata;
      end
      root_q_ff <= root_mem[root_raddr];
      if (accept_in && keep) begin
         edge_mem[edge_total_ff[EIDX_W-1:0]] <= {req_row_node, req_col_node, w_in};
      end
      edge_q_ff <= edge_mem[sc_ff[EIDX_W-1:0]];
   end

   // Sequencer and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_LOAD;
         node_count_ff <= CFG_W'(5);
         edge_total_ff <= '0;
         rsp_valid_ff  <= 1'b0;
         rd_v_ff       <= 1'b0;
         rl_v_ff       <= 1'b0;
         best_v_ff     <= 1'b0;
         prev_v_ff     <= 1'b0;
         pend_v_ff     <= 1'b0;
         acc_ff        <= '0;
         sc_ff         <= '0;
         cnt_ff        <= '0;
      end else begin
         if (csr_write) begin
            node_count_ff <= csr_wdata;
         end
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_LOAD: begin
               if (accept_in) begin
                  if (keep) begin
                     edge_total_ff <= edge_total_ff + 1'b1;
                  end
                  if (req_last_entry) begin
                     state_ff  <= ST_RINIT;
                     cnt_ff    <= '0;
                     acc_ff    <= '0;
                     prev_v_ff <= 1'b0;
                     pend_v_ff <= 1'b0;
                  end
               end
            end
            ST_RINIT: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == NCNT_W'(MAX_NODES - 1)) begin
                  sc_ff     <= '0;
                  rd_v_ff   <= 1'b0;
                  best_v_ff <= 1'b0;
                  state_ff  <= (edge_total_ff == '0) ? ST_FINISH : ST_SCAN;
               end
            end
            ST_SCAN: begin
               if (sc_ff < edge_total_ff) begin
                  sc_ff     <= sc_ff + 1'b1;
                  rd_v_ff   <= 1'b1;
                  rd_idx_ff <= sc_ff[EIDX_W-1:0];
               end else begin
                  rd_v_ff <= 1'b0;
               end
               if (cand) begin
                  best_v_ff    <= 1'b1;
                  best_key_ff  <= q_key;
                  best_w_ff    <= q_w;
                  best_from_ff <= edge_q_ff[EDGE_W-1 -: NODE_W];
                  best_to_ff   <= edge_q_ff[WEIGHT_BITS +: NODE_W];
               end
               if (sc_ff == edge_total_ff && !rd_v_ff) begin
                  state_ff <= best_v_ff ? ST_FIND_A : ST_FINISH;
               end
            end
            ST_FIND_A: state_ff <= ST_FIND_B;
            ST_FIND_B: begin
               ra_ff    <= root_q_ff;
               state_ff <= ST_CHECK;
            end
            ST_CHECK: begin
               rb_ff       <= root_q_ff;
               prev_v_ff   <= 1'b1;
               prev_key_ff <= best_key_ff;
               if (root_q_ff == ra_ff) begin
                  // closes a cycle: look for the next edge
                  sc_ff     <= '0;
                  best_v_ff <= 1'b0;
                  state_ff  <= ST_SCAN;
               end else begin
                  state_ff <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               // earlier accepted edge goes out once the next is known
               if (!pend_v_ff || out_free) begin
                  if (pend_v_ff) begin
                     rsp_valid_ff <= 1'b1;
                     rsp_from_ff  <= pend_from_ff;
                     rsp_to_ff    <= pend_to_ff;
                     rsp_w_ff     <= WT_W'(pend_w_ff);
                     rsp_last_ff  <= 1'b0;
                     rsp_empty_ff <= 1'b0;
                  end
                  pend_v_ff    <= 1'b1;
                  pend_from_ff <= best_from_ff;
                  pend_to_ff   <= best_to_ff;
                  pend_w_ff    <= best_w_ff;
                  acc_ff       <= acc_ff + 1'b1;
                  cnt_ff       <= '0;
                  rl_v_ff      <= 1'b0;
                  if (NUSE_W'(acc_ff) + 1'b1 == n_use - 1'b1) begin
                     state_ff <= ST_FINISH;
                  end else begin
                     state_ff <= ST_RELABEL;
                  end
               end
            end
            ST_RELABEL: begin
               // merge component rb into ra, one entry per cycle
               if (cnt_ff < NCNT_W'(MAX_NODES)) begin
                  cnt_ff    <= cnt_ff + 1'b1;
                  rl_v_ff   <= 1'b1;
                  rl_idx_ff <= cnt_ff[NODE_BITS-1:0];
               end else begin
                  rl_v_ff   <= 1'b0;
                  sc_ff     <= '0;
                  best_v_ff <= 1'b0;
                  state_ff  <= ST_SCAN;
               end
            end
            ST_FINISH: begin
               if (out_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_last_ff   <= 1'b1;
                  rsp_empty_ff  <= !pend_v_ff;
                  rsp_from_ff   <= pend_v_ff ? pend_from_ff : '0;
                  rsp_to_ff     <= pend_v_ff ? pend_to_ff : '0;
                  rsp_w_ff      <= pend_v_ff ? WT_W'(pend_w_ff) : '0;
                  pend_v_ff     <= 1'b0;
                  edge_total_ff <= '0;
                  state_ff      <= ST_LOAD;
               end
            end
            default: state_ff <= ST_LOAD;
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_tree_from   = rsp_from_ff;
   assign rsp_tree_to     = rsp_to_ff;
   assign rsp_tree_weight = rsp_w_ff;
   assign rsp_tree_last   = rsp_last_ff;
   assign rsp_tree_empty  = rsp_empty_ff;

endmodule
